// ===== sv/at_rfp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// AT response frame parser package
// Match states, event codes, drive codes, characters and display patterns
// shared by the parser.
// ----------------------------------------------------------------------------
package at_rfp_pkg;

  // match state, one-hot
  typedef enum logic [3:0] {
    MODE_IDLE = 4'b0001,
    MODE_HDR  = 4'b0010,
    MODE_OK   = 4'b0100,
    MODE_ERR  = 4'b1000
  } mode_t;

  typedef enum logic [2:0] {
    EV_NONE   = 3'd0,
    EV_OK     = 3'd1,
    EV_ERROR  = 3'd2,
    EV_HEADER = 3'd3,
    EV_BYTE   = 3'd4,
    EV_DONE   = 3'd5
  } event_t;

  typedef enum logic [1:0] {
    DRIVE_STOP = 2'd0,
    DRIVE_FWD  = 2'd1,
    DRIVE_REV  = 2'd2
  } drive_t;

  localparam logic [7:0] CH_O     = 8'h4F;
  localparam logic [7:0] CH_K     = 8'h4B;
  localparam logic [7:0] CH_E     = 8'h45;
  localparam logic [7:0] CH_R     = 8'h52;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_I     = 8'h49;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_D     = 8'h44;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_M     = 8'h4D;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_TWO   = 8'h32;
  localparam logic [7:0] DIGIT_ZERO = 8'h30;

  localparam logic [7:0] OK_LEN  = 8'd2;
  localparam logic [7:0] ERR_LEN = 8'd5;

  // header cursor positions after the fixed text
  localparam logic [7:0] HPOS_ID    = 8'd5;
  localparam logic [7:0] HPOS_SKIP  = 8'd6;
  localparam logic [7:0] HPOS_DIG1  = 8'd7;
  localparam logic [7:0] HPOS_DIG2  = 8'd8;
  localparam logic [7:0] HPOS_COLON = 8'd9;

  localparam logic [7:0] SEG_FWD  = 8'h80;
  localparam logic [7:0] SEG_REV  = 8'h90;
  localparam logic [7:0] SEG_STOP = 8'h8C;
  localparam logic [7:0] SEG_NONE = 8'hBF;

  function automatic logic [7:0] ok_char(input logic idx);
    logic [7:0] c;
    c = idx ? CH_K : CH_O;
    return c;
  endfunction

  function automatic logic [7:0] err_char(input logic [2:0] idx);
    logic [7:0] c;
    unique case (idx)
      3'd0:    c = CH_E;
      3'd3:    c = CH_O;
      default: c = CH_R;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] hdr_char(input logic [2:0] idx);
    logic [7:0] c;
    unique case (idx)
      3'd0:    c = CH_PLUS;
      3'd1:    c = CH_I;
      3'd2:    c = CH_P;
      3'd3:    c = CH_D;
      default: c = CH_COMMA;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== sv/at_response_frame_parser.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// AT response frame parser
// Parses modem responses (OK, ERROR, +IPD frames) byte by byte and decodes
// a motor command from the frame payload.
// ----------------------------------------------------------------------------
// Usage:
//   input channel : in_valid / in_stall / in_rx_byte, one UART byte per
//                   transaction
//   result channel: out_valid / out_stall / out_* fields, exactly one result
//                   transaction for every input transaction, in order
// A byte accepted at an edge has its result in the output register after
// that edge. Throughput is one byte per cycle unless out_stall holds it; the
// parse state and the result register both update in the accepting cycle.
// in_stall is raised only while the result register holds a result that the
// receiver is stalling; as soon as it is taken the next byte goes in during
// the same cycle. While stalled the result holds steady.
// Reset returns the matcher to idle, clears id, length, kept payload bytes
// and sets the motor to stopped; no result is pending after reset.
// ----------------------------------------------------------------------------
module at_response_frame_parser (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_rx_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [2:0]      out_event_res,
  output logic [7:0]      out_payload_byte,
  output logic [7:0]      out_payload_index,
  output logic [7:0]      out_link_id,
  output logic [7:0]      out_message_length,
  output logic [1:0]      out_motor_drive,
  output logic [7:0]      out_segment_code
);

  at_rfp_pkg::mode_t  mode_r, mode_nxt;
  logic [7:0]         position_r, position_nxt;
  logic               in_payload_r, in_payload_nxt;
  logic [7:0]         id_r, id_nxt;
  logic [7:0]         length_r, length_nxt;
  logic [7:0]         first_r, first_nxt;
  logic [7:0]         second_r, second_nxt;
  at_rfp_pkg::drive_t drive_r, drive_nxt;

  at_rfp_pkg::event_t ev_nxt;
  logic [7:0]         pbyte_nxt, pidx_nxt, seg_nxt;

  logic               out_valid_r;
  at_rfp_pkg::event_t ev_r;
  logic [7:0]         pbyte_r, pidx_r, seg_r;

  logic in_fire;

  assign in_stall = out_valid_r & out_stall;
  assign in_fire  = in_valid & ~in_stall;

  always_comb begin
    logic [7:0]         b;
    logic [7:0]         pos;
    logic [7:0]         digit;
    at_rfp_pkg::mode_t  mode;

    b     = in_rx_byte;
    pos   = position_r;
    digit = b - at_rfp_pkg::DIGIT_ZERO;
    mode  = mode_r;

    mode_nxt       = mode_r;
    position_nxt   = position_r;
    in_payload_nxt = in_payload_r;
    id_nxt         = id_r;
    length_nxt     = length_r;
    first_nxt      = first_r;
    second_nxt     = second_r;
    drive_nxt      = drive_r;
    ev_nxt         = at_rfp_pkg::EV_NONE;
    pbyte_nxt      = 8'd0;
    pidx_nxt       = 8'd0;
    seg_nxt        = 8'd0;

    if (in_payload_r) begin
      if (pos < length_r) begin
        if (pos == 8'd0) first_nxt = b;
        if (pos == 8'd1) second_nxt = b;
        pbyte_nxt = b;
        pidx_nxt  = pos;
        pos       = pos + 8'd1;
        ev_nxt    = at_rfp_pkg::EV_BYTE;
      end
      position_nxt = pos;
      if (pos >= length_r) begin
        // message complete: decode the command from the first two bytes
        if (first_nxt == at_rfp_pkg::CH_M && length_r > 8'd1) begin
          priority if (second_nxt == at_rfp_pkg::CH_ONE) begin
            drive_nxt = at_rfp_pkg::DRIVE_FWD;
            seg_nxt   = at_rfp_pkg::SEG_FWD;
          end else if (second_nxt == at_rfp_pkg::CH_TWO) begin
            drive_nxt = at_rfp_pkg::DRIVE_REV;
            seg_nxt   = at_rfp_pkg::SEG_REV;
          end else begin
            drive_nxt = at_rfp_pkg::DRIVE_STOP;
            seg_nxt   = at_rfp_pkg::SEG_STOP;
          end
        end else begin
          seg_nxt = at_rfp_pkg::SEG_NONE;
        end
        ev_nxt         = at_rfp_pkg::EV_DONE;
        in_payload_nxt = 1'b0;
        position_nxt   = 8'd0;
        mode_nxt       = at_rfp_pkg::MODE_IDLE;
      end
    end else begin
      if (mode_r == at_rfp_pkg::MODE_IDLE) begin
        priority if (b == at_rfp_pkg::CH_O) mode = at_rfp_pkg::MODE_OK;
        else if (b == at_rfp_pkg::CH_PLUS)  mode = at_rfp_pkg::MODE_HDR;
        else if (b == at_rfp_pkg::CH_E)     mode = at_rfp_pkg::MODE_ERR;
        else                                mode = at_rfp_pkg::MODE_IDLE;
      end
      mode_nxt = mode;
      unique case (mode)
        at_rfp_pkg::MODE_OK: begin
          if (pos < at_rfp_pkg::OK_LEN) begin
            if (b == at_rfp_pkg::ok_char(pos[0])) begin
              pos = pos + 8'd1;
            end else begin
              pos      = 8'd0;
              mode_nxt = at_rfp_pkg::MODE_IDLE;
            end
          end
          position_nxt = pos;
          if (pos >= at_rfp_pkg::OK_LEN) begin
            position_nxt = 8'd0;
            mode_nxt     = at_rfp_pkg::MODE_IDLE;
            ev_nxt       = at_rfp_pkg::EV_OK;
          end
        end
        at_rfp_pkg::MODE_ERR: begin
          if (pos < at_rfp_pkg::ERR_LEN) begin
            if (b == at_rfp_pkg::err_char(pos[2:0])) begin
              pos = pos + 8'd1;
            end else begin
              pos      = 8'd0;
              mode_nxt = at_rfp_pkg::MODE_IDLE;
            end
          end
          position_nxt = pos;
          if (pos >= at_rfp_pkg::ERR_LEN) begin
            position_nxt = 8'd0;
            mode_nxt     = at_rfp_pkg::MODE_IDLE;
            ev_nxt       = at_rfp_pkg::EV_ERROR;
          end
        end
        at_rfp_pkg::MODE_HDR: begin
          priority if (pos < at_rfp_pkg::HPOS_ID) begin
            if (b == at_rfp_pkg::hdr_char(pos[2:0])) begin
              position_nxt = pos + 8'd1;
            end else begin
              position_nxt = 8'd0;
              mode_nxt     = at_rfp_pkg::MODE_IDLE;
            end
          end else if (pos == at_rfp_pkg::HPOS_ID) begin
            id_nxt       = b;
            position_nxt = at_rfp_pkg::HPOS_SKIP;
          end else if (pos == at_rfp_pkg::HPOS_SKIP) begin
            position_nxt = at_rfp_pkg::HPOS_DIG1;
          end else if (pos == at_rfp_pkg::HPOS_DIG1) begin
            length_nxt   = digit;
            position_nxt = at_rfp_pkg::HPOS_DIG2;
          end else if (pos == at_rfp_pkg::HPOS_DIG2) begin
            if (b == at_rfp_pkg::CH_COLON) begin
              position_nxt   = 8'd0;
              in_payload_nxt = 1'b1;
              ev_nxt         = at_rfp_pkg::EV_HEADER;
            end else begin
              // tens * 10 + units, wrapping at 8 bits
              length_nxt   = {length_r[4:0], 3'b000} + {length_r[6:0], 1'b0} + digit;
              position_nxt = at_rfp_pkg::HPOS_COLON;
            end
          end else if (pos == at_rfp_pkg::HPOS_COLON && b == at_rfp_pkg::CH_COLON) begin
            position_nxt   = 8'd0;
            in_payload_nxt = 1'b1;
            ev_nxt         = at_rfp_pkg::EV_HEADER;
          end else begin
            position_nxt = 8'd0;
            mode_nxt     = at_rfp_pkg::MODE_IDLE;
          end
        end
        default: begin
          // idle and the byte starts no word: ignored
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= at_rfp_pkg::MODE_IDLE;
      position_r   <= 8'd0;
      in_payload_r <= 1'b0;
      id_r         <= 8'd0;
      length_r     <= 8'd0;
      first_r      <= 8'd0;
      second_r     <= 8'd0;
      drive_r      <= at_rfp_pkg::DRIVE_STOP;
      out_valid_r  <= 1'b0;
    end else begin
      if (in_fire) begin
        mode_r       <= mode_nxt;
        position_r   <= position_nxt;
        in_payload_r <= in_payload_nxt;
        id_r         <= id_nxt;
        length_r     <= length_nxt;
        first_r      <= first_nxt;
        second_r     <= second_nxt;
        drive_r      <= drive_nxt;
        out_valid_r  <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload, loaded with each accepted transaction
  always_ff @(posedge clk) begin
    if (in_fire) begin
      ev_r    <= ev_nxt;
      pbyte_r <= pbyte_nxt;
      pidx_r  <= pidx_nxt;
      seg_r   <= seg_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_event_res      = ev_r;
  assign out_payload_byte   = pbyte_r;
  assign out_payload_index  = pidx_r;
  assign out_link_id        = id_r;
  assign out_message_length = length_r;
  assign out_motor_drive    = drive_r;
  assign out_segment_code   = seg_r;

  // a result appears only after an accepted transaction
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(in_fire))
    else $error("result without accepted transaction");

  // a byte taken inside a payload is always reported as payload or completion
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_payload_r) |=>
      (out_event_res == at_rfp_pkg::EV_BYTE || out_event_res == at_rfp_pkg::EV_DONE))
    else $error("payload byte lost its event");

  // a header completion always enters the payload phase
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && ev_nxt == at_rfp_pkg::EV_HEADER) |=> (in_payload_r && position_r == 8'd0))
    else $error("header done without payload phase");

endmodule
`default_nettype wire
